// ----- rtl/core/skyline_lightmap_block_allocator_top_defines.svh -----
// assertion helpers shared by the allocator rtl
`ifndef SKYLINE_LIGHTMAP_BLOCK_ALLOCATOR_TOP_DEFINES_SVH
`define SKYLINE_LIGHTMAP_BLOCK_ALLOCATOR_TOP_DEFINES_SVH

// same-cycle implication, quiet during reset
`define SLBA_ASSERT_NOW(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet during reset
`define SLBA_ASSERT_NEXT(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/slba_pkg.sv -----
package slba_pkg;

  // default page edge in cells
  localparam int PAGE_SIZE_DEF = 128;

  // extent to cell count shift
  localparam int CELL_SHIFT = 4;

  // page number saturation point
  localparam logic [7:0] PAGE_MAX = 8'd255;

  // request kinds
  localparam logic MODE_ALLOC   = 1'b0;
  localparam logic MODE_RESTART = 1'b1;

  // result status codes
  localparam logic [1:0] ST_PLACED   = 2'd0;
  localparam logic [1:0] ST_NEW_PAGE = 2'd1;
  localparam logic [1:0] ST_FAIL     = 2'd2;

endpackage

// ----- rtl/core/slba_ram.sv -----
module slba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/skyline_lightmap_block_allocator_top.sv -----
// sequence: restart clears the skyline; an allocate scans each start column of the
//   page (one skyline read per cycle, a window stops early once it cannot beat the best
//   top), then raises the covered columns
// a retry on a fresh page adds a skyline clear and a second scan
// throughput: one request at a time, the skyline memory (one write, one read port) sets the pace
// reset: synchronous active-low; afterwards a clearing pass zeroes the skyline before ready
module skyline_lightmap_block_allocator_top #(
  parameter int PAGE_SIZE = slba_pkg::PAGE_SIZE_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // extent_s [10:0], extent_t [21:11], zero [23:22]
  input  logic        in_tuser,   // mode [0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // x_pos [6:0], y_pos [13:7], page [21:14], zero [23:22]
  output logic [1:0]  out_tuser   // status [1:0]
);

  import slba_pkg::*;

  `include "skyline_lightmap_block_allocator_top_defines.svh"

  localparam int AW = $clog2(PAGE_SIZE);
  localparam int HW = $clog2(PAGE_SIZE + 1);
  localparam int NW = (AW + 2 > 9) ? AW + 2 : 9;
  localparam int XW = (AW > 7) ? AW : 7;
  localparam int YW = (HW > 7) ? HW : 7;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_START,
    S_SCAN,
    S_DECIDE,
    S_RAISE,
    S_RESULT
  } state_t;

  state_t          state_r;
  state_t          ret_r;
  logic [AW-1:0]   clr_cnt_r;
  logic [7:0]      w_r;
  logic [7:0]      h_r;
  logic [AW-1:0]   i_r;
  logic [7:0]      j_r;
  logic [HW-1:0]   m_r;
  logic [HW-1:0]   best_r;
  logic [AW-1:0]   bx_r;
  logic            rd_pend_r;
  logic            rd_last_r;
  logic            attempt_r;
  logic [7:0]      page_r;
  logic [6:0]      res_x_r;
  logic [6:0]      res_y_r;
  logic [1:0]      res_st_r;
  logic            out_tvalid_r;
  logic [23:0]     out_tdata_r;
  logic [1:0]      out_tuser_r;

  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [HW-1:0]   ram_wdata;
  logic [AW-1:0]   ram_raddr;
  logic [HW-1:0]   ram_rdata;

  logic [HW-1:0]   m_new;
  logic            win_brk;
  logic            win_end;
  logic            last_start;
  logic            scan_any;
  logic            fits;
  logic [NW-1:0]   sum_top;
  logic [HW-1:0]   new_top;
  logic [NW-1:0]   rd_addr_w;
  logic [NW-1:0]   wr_addr_w;
  logic [XW-1:0]   bx_ext;
  logic [YW-1:0]   best_ext;
  logic [7:0]      w_in;
  logic [7:0]      h_in;

  // skyline store
  slba_ram #(
    .WIDTH (HW),
    .DEPTH (PAGE_SIZE)
  ) u_skyline (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // block size from the request extents
  assign w_in = 8'(in_tdata[10:0] >> CELL_SHIFT) + 8'd1;
  assign h_in = 8'(in_tdata[21:11] >> CELL_SHIFT) + 8'd1;

  // scan window bookkeeping
  assign scan_any   = NW'(w_r) < NW'(PAGE_SIZE);
  assign last_start = (NW'(i_r) + NW'(1)) == (NW'(PAGE_SIZE) - NW'(w_r));
  assign m_new      = (ram_rdata > m_r) ? ram_rdata : m_r;
  assign win_brk    = rd_pend_r && (m_new >= best_r);
  assign win_end    = rd_pend_r && (win_brk || rd_last_r);

  // fit check against the page height
  assign sum_top = NW'(best_r) + NW'(h_r);
  assign fits    = sum_top <= NW'(PAGE_SIZE);
  assign new_top = sum_top[HW-1:0];

  // memory addressing
  assign rd_addr_w = NW'(i_r) + NW'(j_r);
  assign wr_addr_w = NW'(bx_r) + NW'(j_r);
  assign ram_raddr = rd_addr_w[AW-1:0];

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_cnt_r;
    ram_wdata = '0;
    unique case (state_r)
      S_CLEAR: begin
        ram_we = 1'b1;
      end
      S_RAISE: begin
        ram_we    = 1'b1;
        ram_waddr = wr_addr_w[AW-1:0];
        ram_wdata = new_top;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // result position, masked to the field width
  assign bx_ext   = XW'(bx_r);
  assign best_ext = YW'(best_r);

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      ret_r        <= S_IDLE;
      clr_cnt_r    <= '0;
      rd_pend_r    <= 1'b0;
      attempt_r    <= 1'b0;
      page_r       <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      // the result state handles its own output handshake
      if (out_tvalid_r && out_tready && state_r != S_RESULT) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        // zero the skyline one column a cycle
        S_CLEAR: begin
          if (clr_cnt_r == AW'(PAGE_SIZE - 1)) begin
            state_r <= ret_r;
          end else begin
            clr_cnt_r <= clr_cnt_r + AW'(1);
          end
        end
        // take a request
        S_IDLE: begin
          if (in_tvalid) begin
            w_r       <= w_in;
            h_r       <= h_in;
            attempt_r <= 1'b0;
            if (in_tuser == MODE_RESTART) begin
              page_r    <= '0;
              res_x_r   <= '0;
              res_y_r   <= '0;
              res_st_r  <= ST_FAIL;
              clr_cnt_r <= '0;
              ret_r     <= S_RESULT;
              state_r   <= S_CLEAR;
            end else begin
              state_r <= S_START;
            end
          end
        end
        // fresh search
        S_START: begin
          i_r       <= '0;
          j_r       <= '0;
          m_r       <= '0;
          best_r    <= HW'(PAGE_SIZE);
          bx_r      <= '0;
          rd_pend_r <= 1'b0;
          state_r   <= scan_any ? S_SCAN : S_DECIDE;
        end
        // window max over the block width, keeping the first strictly lowest
        S_SCAN: begin
          if (win_end) begin
            if (!win_brk) begin
              best_r <= m_new;
              bx_r   <= i_r;
            end
            m_r       <= '0;
            j_r       <= '0;
            rd_pend_r <= 1'b0;
            if (last_start) begin
              state_r <= S_DECIDE;
            end else begin
              i_r <= i_r + AW'(1);
            end
          end else begin
            if (rd_pend_r) begin
              m_r <= m_new;
            end
            if (j_r < w_r) begin
              j_r       <= j_r + 8'd1;
              rd_pend_r <= 1'b1;
              rd_last_r <= (j_r == w_r - 8'd1);
            end else begin
              rd_pend_r <= 1'b0;
            end
          end
        end
        // place, retry on a new page, or give up
        S_DECIDE: begin
          if (fits) begin
            j_r     <= '0;
            state_r <= S_RAISE;
          end else if (!attempt_r) begin
            attempt_r <= 1'b1;
            if (page_r != PAGE_MAX) begin
              page_r <= page_r + 8'd1;
            end
            clr_cnt_r <= '0;
            ret_r     <= S_START;
            state_r   <= S_CLEAR;
          end else begin
            res_x_r  <= '0;
            res_y_r  <= '0;
            res_st_r <= ST_FAIL;
            state_r  <= S_RESULT;
          end
        end
        // raise the covered columns
        S_RAISE: begin
          j_r <= j_r + 8'd1;
          if (j_r == w_r - 8'd1) begin
            res_x_r  <= bx_ext[6:0];
            res_y_r  <= best_ext[6:0];
            res_st_r <= attempt_r ? ST_NEW_PAGE : ST_PLACED;
            state_r  <= S_RESULT;
          end
        end
        // hand the result to the output register
        S_RESULT: begin
          if (!out_tvalid_r || out_tready) begin
            out_tvalid_r <= 1'b1;
            out_tdata_r  <= {2'b00, page_r, res_y_r, res_x_r};
            out_tuser_r  <= res_st_r;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // checks
  `SLBA_ASSERT_NEXT(a_busy_after_req, in_tvalid && in_tready, !in_tready, "ready after request")
  `SLBA_ASSERT_NOW(a_best_in_page, state_r == S_DECIDE, best_r <= HW'(PAGE_SIZE), "best top out of page")
  `SLBA_ASSERT_NOW(a_retry_page, attempt_r, page_r != 8'd0, "retry without page advance")
  `SLBA_ASSERT_NOW(a_fail_zero_pos, out_tvalid && out_tuser == ST_FAIL, out_tdata[13:0] == 14'd0, "fail result with position")

endmodule
